// ----- sv/pxg_pkg.sv -----
// ----------------------------------------------------------------------------
// pxg_pkg: shared types and constants
// Result slot codes, register indexes and the structs that pass between the
// pipeline stage, the gradient unit and the result queue.
// ----------------------------------------------------------------------------
package pxg_pkg;

   // configuration port
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 12;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH  = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT = 4'd1;
   localparam logic [CSR_DATA_W-1:0]  IMAGE_WIDTH_RESET  = 12'd640;
   localparam logic [CSR_DATA_W-1:0]  IMAGE_HEIGHT_RESET = 12'd480;

   // field widths
   localparam int PIXEL_W = 8;
   localparam int COORD_W = 11;

   // result slots of one input pixel, in delivery order
   localparam int NUM_SLOTS = 4;
   localparam logic [1:0] SLOT_PREV_INNER = 2'd0;  // row above, column to the left
   localparam logic [1:0] SLOT_PREV_LAST  = 2'd1;  // row above, last column
   localparam logic [1:0] SLOT_THIS_INNER = 2'd2;  // last row, column to the left
   localparam logic [1:0] SLOT_THIS_LAST  = 2'd3;  // last row, last column

   // result queue depth, in pixel entries
   localparam int RQ_DEPTH = 4;
   localparam int RQ_PTR_W = 2;
   localparam int RQ_CNT_W = 3;

   // position flags and output coordinates of a pixel in the compute stage
   typedef struct packed {
      logic [PIXEL_W-1:0] pixel;
      logic               row_ge1;
      logic               row_ge2;
      logic               col_ge1;
      logic               col_ge2;
      logic               last_col;
      logic               last_row;
      logic [COORD_W-1:0] row_prev;
      logic [COORD_W-1:0] row_this;
      logic [COORD_W-1:0] col_prev;
      logic [COORD_W-1:0] col_last;
   } stage_type;

   // every result one pixel causes, with a mask of the ones that exist
   typedef struct packed {
      logic [NUM_SLOTS-1:0]              mask;
      logic [NUM_SLOTS-1:0][PIXEL_W-1:0] gradient;
      logic [COORD_W-1:0]                row_prev;
      logic [COORD_W-1:0]                row_this;
      logic [COORD_W-1:0]                col_prev;
      logic [COORD_W-1:0]                col_last;
   } result_set_type;

endpackage

// ----- sv/pxg_ram.sv -----
// ----------------------------------------------------------------------------
// pxg_ram: generic single-port-write, single-port-read RAM
// Registered read with read-first behaviour on a same-address collision.
// ----------------------------------------------------------------------------
module pxg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/pxg_gradient.sv -----
// ----------------------------------------------------------------------------
// pxg_gradient: column taps and Prewitt X arithmetic
// Holds the two previous columns of the three rows, forms the four possible
// results of one pixel and the data written back to the line stores.
// ----------------------------------------------------------------------------
module pxg_gradient (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       restart,
   input  logic                       stage_valid,
   input  pxg_pkg::stage_type         stage,
   input  logic [pxg_pkg::PIXEL_W-1:0] older_data,
   input  logic [pxg_pkg::PIXEL_W-1:0] prev_data,
   output logic [pxg_pkg::PIXEL_W-1:0] older_wr_data,
   output logic [pxg_pkg::PIXEL_W-1:0] prev_wr_data,
   output pxg_pkg::result_set_type    result
);

   logic [1:0][pxg_pkg::PIXEL_W-1:0] cur_tap_ff, cur_tap_in;
   logic [1:0][pxg_pkg::PIXEL_W-1:0] prev_tap_ff, prev_tap_in;
   logic [1:0][pxg_pkg::PIXEL_W-1:0] older_tap_ff, older_tap_in;

   logic [1:0][pxg_pkg::PIXEL_W-1:0] taps_a, taps_b;
   logic [pxg_pkg::PIXEL_W-1:0]      top_a, top_b;
   logic [pxg_pkg::PIXEL_W-1:0]      di_a, di_b, di_p, di_c;
   logic [pxg_pkg::PIXEL_W-1:0]      dl_a, dl_b, dl_p, dl_c;

   // right minus left, left column clamped at the frame edge
   function automatic logic [pxg_pkg::PIXEL_W-1:0] diff_inner(
      input logic [pxg_pkg::PIXEL_W-1:0]      v,
      input logic [1:0][pxg_pkg::PIXEL_W-1:0] taps,
      input logic                             col_ge2
   );
      logic [pxg_pkg::PIXEL_W-1:0] left;
      left = col_ge2 ? taps[1] : taps[0];
      return v - left;
   endfunction

   // right minus left at the last column, the right neighbour replicated
   function automatic logic [pxg_pkg::PIXEL_W-1:0] diff_last(
      input logic [pxg_pkg::PIXEL_W-1:0]      v,
      input logic [1:0][pxg_pkg::PIXEL_W-1:0] taps,
      input logic                             col_ge1
   );
      logic [pxg_pkg::PIXEL_W-1:0] left;
      left = col_ge1 ? taps[0] : v;
      return v - left;
   endfunction

   // top row of each window, replicated near the top edge
   always_comb begin
      top_a  = stage.row_ge2 ? older_data : prev_data;
      taps_a = stage.row_ge2 ? older_tap_ff : prev_tap_ff;
      top_b  = stage.row_ge1 ? prev_data : stage.pixel;
      taps_b = stage.row_ge1 ? prev_tap_ff : cur_tap_ff;
   end

   // column differences
   always_comb begin
      di_a = diff_inner(top_a, taps_a, stage.col_ge2);
      di_b = diff_inner(top_b, taps_b, stage.col_ge2);
      di_p = diff_inner(prev_data, prev_tap_ff, stage.col_ge2);
      di_c = diff_inner(stage.pixel, cur_tap_ff, stage.col_ge2);
      dl_a = diff_last(top_a, taps_a, stage.col_ge1);
      dl_b = diff_last(top_b, taps_b, stage.col_ge1);
      dl_p = diff_last(prev_data, prev_tap_ff, stage.col_ge1);
      dl_c = diff_last(stage.pixel, cur_tap_ff, stage.col_ge1);
   end

   // result set: bottom row doubled on the last row
   always_comb begin
      result = '0;
      result.mask[pxg_pkg::SLOT_PREV_INNER] = stage_valid & stage.row_ge1 & stage.col_ge1;
      result.mask[pxg_pkg::SLOT_PREV_LAST]  = stage_valid & stage.row_ge1 & stage.last_col;
      result.mask[pxg_pkg::SLOT_THIS_INNER] = stage_valid & stage.last_row & stage.col_ge1;
      result.mask[pxg_pkg::SLOT_THIS_LAST]  = stage_valid & stage.last_row & stage.last_col;
      result.gradient[pxg_pkg::SLOT_PREV_INNER] = di_a + di_p + di_c;
      result.gradient[pxg_pkg::SLOT_PREV_LAST]  = dl_a + dl_p + dl_c;
      result.gradient[pxg_pkg::SLOT_THIS_INNER] = di_b + {di_c[pxg_pkg::PIXEL_W-2:0], 1'b0};
      result.gradient[pxg_pkg::SLOT_THIS_LAST]  = dl_b + {dl_c[pxg_pkg::PIXEL_W-2:0], 1'b0};
      result.row_prev = stage.row_prev;
      result.row_this = stage.row_this;
      result.col_prev = stage.col_prev;
      result.col_last = stage.col_last;
   end

   // line store write-back: each row moves one store down
   assign older_wr_data = prev_data;
   assign prev_wr_data  = stage.pixel;

   // tap shift
   always_comb begin
      cur_tap_in   = cur_tap_ff;
      prev_tap_in  = prev_tap_ff;
      older_tap_in = older_tap_ff;
      if (restart) begin
         cur_tap_in   = '0;
         prev_tap_in  = '0;
         older_tap_in = '0;
      end else if (stage_valid) begin
         cur_tap_in   = {cur_tap_ff[0], stage.pixel};
         prev_tap_in  = {prev_tap_ff[0], prev_data};
         older_tap_in = {older_tap_ff[0], older_data};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_tap_ff   <= '0;
         prev_tap_ff  <= '0;
         older_tap_ff <= '0;
      end else begin
         cur_tap_ff   <= cur_tap_in;
         prev_tap_ff  <= prev_tap_in;
         older_tap_ff <= older_tap_in;
      end
   end

endmodule

// ----- sv/pxg_result_queue.sv -----
// ----------------------------------------------------------------------------
// pxg_result_queue: per-pixel result queue and serialiser
// Stores the result sets of a few pixels and hands out their results one
// transfer at a time, in slot order.
// ----------------------------------------------------------------------------
module pxg_result_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  pxg_pkg::result_set_type       push_set,
   output logic [pxg_pkg::RQ_CNT_W-1:0]  level,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [31:0]                   rsp_tdata,
   output logic                          rsp_tlast,
   output logic                          rsp_tuser
);

   pxg_pkg::result_set_type               entry_ff [pxg_pkg::RQ_DEPTH];
   logic [pxg_pkg::RQ_PTR_W-1:0]          wr_ptr_ff, wr_ptr_in;
   logic [pxg_pkg::RQ_PTR_W-1:0]          rd_ptr_ff, rd_ptr_in;
   logic [pxg_pkg::RQ_CNT_W-1:0]          count_ff, count_in;
   logic [pxg_pkg::NUM_SLOTS-1:0]         done_ff, done_in;

   pxg_pkg::result_set_type               head;
   logic [pxg_pkg::NUM_SLOTS-1:0]         remain;
   logic [1:0]                            slot;
   logic                                  last;
   logic                                  push;
   logic                                  pop;
   logic                                  xfer;

   // head entry and the next slot still owed
   always_comb begin
      head   = entry_ff[rd_ptr_ff];
      remain = head.mask & ~done_ff;
      slot   = pxg_pkg::SLOT_THIS_LAST;
      for (int i = pxg_pkg::NUM_SLOTS - 1; i >= 0; i--) begin
         if (remain[i]) begin
            slot = 2'(i);
         end
      end
      last = (remain & (remain - pxg_pkg::NUM_SLOTS'(1))) == '0;
   end

   assign rsp_tvalid = count_ff != '0;
   assign xfer       = rsp_tvalid & rsp_tready;
   assign pop        = xfer & last;
   assign push       = push_set.mask != '0;

   // output fields
   always_comb begin
      rsp_tdata        = '0;
      rsp_tdata[7:0]   = head.gradient[slot];
      rsp_tdata[18:8]  = slot[1] ? head.row_this : head.row_prev;
      rsp_tdata[29:19] = slot[0] ? head.col_last : head.col_prev;
      rsp_tlast        = last;
      rsp_tuser        = slot == pxg_pkg::SLOT_THIS_LAST;
   end

   // pointers, fill level and delivered slots
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + pxg_pkg::RQ_CNT_W'(push) - pxg_pkg::RQ_CNT_W'(pop);
      done_in   = done_ff;
      if (pop) begin
         done_in = '0;
      end else if (xfer) begin
         done_in = done_ff | (pxg_pkg::NUM_SLOTS'(1) << slot);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         done_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         done_ff   <= done_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_set;
      end
   end

   assign level = count_ff;

endmodule

// ----- sv/prewitt_x_gradient_filter.sv -----
// ----------------------------------------------------------------------------
// prewitt_x_gradient_filter: streaming 3x3 Prewitt X gradient
// Line stores, position counters and the accept stage of the filter.
// ----------------------------------------------------------------------------
// Takes one 8-bit pixel per clock in raster order and returns the 3x3 Prewitt
// X gradient (right column minus left column over three rows, modulo 256) of
// every pixel, one row behind the input, with replicated borders. A pixel is
// taken every clock while the result port keeps up; its results are formed
// in the compute stage from the registered read of the two line-store RAMs.
// The result port carries one result a clock while rsp_tready is high, so on
// the last row of a frame (two results per pixel, up to four at the right
// column) input is paced by the result port through a four-pixel result
// queue. Writing either size register restarts the frame at row 0, column 0;
// size 0 counts as 1 and sizes above the maximum count as the maximum. The
// line stores need no clearing after reset.
// ----------------------------------------------------------------------------
module prewitt_x_gradient_filter #(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 2048
) (
   input  logic                              clock,
   input  logic                              reset,
   // input pixels
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [7:0]                        req_tdata,   // [7:0] pixel
   // results
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [31:0]                       rsp_tdata,   // [7:0] gradient, [18:8] out_row,
                                                          // [29:19] out_col
   output logic                              rsp_tlast,   // last_of_run
   output logic                              rsp_tuser,   // end_of_frame
   // register writes
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [pxg_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [pxg_pkg::CSR_DATA_W-1:0]    csr_data
);

   localparam int CW    = $clog2(MAX_WIDTH);
   localparam int RW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int DIM_W = 15;

   logic [pxg_pkg::CSR_DATA_W-1:0]  width_ff, width_in;
   logic [pxg_pkg::CSR_DATA_W-1:0]  height_ff, height_in;
   logic [CW-1:0]                   col_ff, col_in;
   logic [RW-1:0]                   row_ff, row_in;
   logic                            b_valid_ff;
   pxg_pkg::stage_type              b_stage_ff, b_stage_in;
   logic [CW-1:0]                   b_addr_ff;
   logic                            fwd_ff, fwd_in;
   logic [pxg_pkg::PIXEL_W-1:0]     fwd_older_ff;
   logic [pxg_pkg::PIXEL_W-1:0]     fwd_prev_ff;

   logic [DIM_W-1:0]                w_ext, h_ext, w_m1_full, h_m1_full;
   logic [CW-1:0]                   w_m1;
   logic [RW-1:0]                   h_m1;
   logic                            accept;
   logic                            restart;
   logic                            last_col, last_row;
   logic [CW-1:0]                   col_m1;
   logic [RW-1:0]                   row_m1;
   logic [pxg_pkg::PIXEL_W-1:0]     older_rd, prev_rd;
   logic [pxg_pkg::PIXEL_W-1:0]     older_eff, prev_eff;
   logic [pxg_pkg::PIXEL_W-1:0]     older_wr_data, prev_wr_data;
   pxg_pkg::result_set_type         result;
   logic [pxg_pkg::RQ_CNT_W-1:0]    level;

   // register writes, any known index restarts the frame
   assign csr_ready = 1'b1;
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      restart   = 1'b0;
      if (csr_valid) begin
         case (csr_index)
            pxg_pkg::CSR_IMAGE_WIDTH: begin
               width_in = csr_data;
               restart  = 1'b1;
            end
            pxg_pkg::CSR_IMAGE_HEIGHT: begin
               height_in = csr_data;
               restart   = 1'b1;
            end
            default: begin
               restart = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= pxg_pkg::IMAGE_WIDTH_RESET;
         height_ff <= pxg_pkg::IMAGE_HEIGHT_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // effective frame size minus one
   always_comb begin
      w_ext = DIM_W'(width_ff);
      h_ext = DIM_W'(height_ff);
      if (w_ext == '0) begin
         w_m1_full = '0;
      end else if (w_ext > DIM_W'(MAX_WIDTH)) begin
         w_m1_full = DIM_W'(MAX_WIDTH - 1);
      end else begin
         w_m1_full = w_ext - DIM_W'(1);
      end
      if (h_ext == '0) begin
         h_m1_full = '0;
      end else if (h_ext > DIM_W'(MAX_HEIGHT)) begin
         h_m1_full = DIM_W'(MAX_HEIGHT - 1);
      end else begin
         h_m1_full = h_ext - DIM_W'(1);
      end
      w_m1 = CW'(w_m1_full);
      h_m1 = RW'(h_m1_full);
   end

   // accept stage: room for this pixel and the one in the compute stage
   assign req_tready = (32'(level) + 32'(b_valid_ff)) < pxg_pkg::RQ_DEPTH;
   assign accept     = req_tvalid & req_tready;

   always_comb begin
      last_col = col_ff == w_m1;
      last_row = row_ff == h_m1;
      col_m1   = col_ff - CW'(1);
      row_m1   = row_ff - RW'(1);
      b_stage_in.pixel    = req_tdata;
      b_stage_in.row_ge1  = row_ff >= RW'(1);
      b_stage_in.row_ge2  = 32'(row_ff) >= 2;
      b_stage_in.col_ge1  = col_ff >= CW'(1);
      b_stage_in.col_ge2  = 32'(col_ff) >= 2;
      b_stage_in.last_col = last_col;
      b_stage_in.last_row = last_row;
      b_stage_in.row_prev = pxg_pkg::COORD_W'(row_m1);
      b_stage_in.row_this = pxg_pkg::COORD_W'(row_ff);
      b_stage_in.col_prev = pxg_pkg::COORD_W'(col_m1);
      b_stage_in.col_last = pxg_pkg::COORD_W'(w_m1);
   end

   // position of the next input pixel
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (restart) begin
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + RW'(1);
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
   end

   // a read that meets the write-back of the same column takes the new data
   assign fwd_in = accept & b_valid_ff & (b_addr_ff == col_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         row_ff     <= '0;
         b_valid_ff <= 1'b0;
         fwd_ff     <= 1'b0;
      end else begin
         col_ff     <= col_in;
         row_ff     <= row_in;
         b_valid_ff <= accept;
         fwd_ff     <= fwd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         b_stage_ff   <= b_stage_in;
         b_addr_ff    <= col_ff;
         fwd_older_ff <= older_wr_data;
         fwd_prev_ff  <= prev_wr_data;
      end
   end

   // line stores
   pxg_ram #(
      .WIDTH (pxg_pkg::PIXEL_W),
      .DEPTH (MAX_WIDTH)
   ) u_older_store (
      .clock   (clock),
      .wr_en   (b_valid_ff),
      .wr_addr (b_addr_ff),
      .wr_data (older_wr_data),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (older_rd)
   );

   pxg_ram #(
      .WIDTH (pxg_pkg::PIXEL_W),
      .DEPTH (MAX_WIDTH)
   ) u_prev_store (
      .clock   (clock),
      .wr_en   (b_valid_ff),
      .wr_addr (b_addr_ff),
      .wr_data (prev_wr_data),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (prev_rd)
   );

   assign older_eff = fwd_ff ? fwd_older_ff : older_rd;
   assign prev_eff  = fwd_ff ? fwd_prev_ff : prev_rd;

   // compute stage
   pxg_gradient u_gradient (
      .clock         (clock),
      .reset         (reset),
      .restart       (restart),
      .stage_valid   (b_valid_ff),
      .stage         (b_stage_ff),
      .older_data    (older_eff),
      .prev_data     (prev_eff),
      .older_wr_data (older_wr_data),
      .prev_wr_data  (prev_wr_data),
      .result        (result)
   );

   // result queue and output port
   pxg_result_queue u_result_queue (
      .clock      (clock),
      .reset      (reset),
      .push_set   (result),
      .level      (level),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: stream test of prewitt_x_gradient_filter
// Raster pixels go in through a queue-fed driver and a monitor predicts every
// gradient at the input transfer and checks each result transfer against the
// oldest prediction. Frame sizes cover single rows, single columns, the
// saturated limits and partial frames, with random gaps and long stalls.
// ----------------------------------------------------------------------------
module tb;

   localparam int MAX_SIZE       = 2048;
   localparam int DRAIN_CYCLES   = 8;
   localparam int HOLD_CYCLES    = 300;
   localparam int CYCLE_LIMIT    = 400000;
   localparam int RANDOM_ITEMS   = 280;
   localparam int SATURATE_ITEMS = 32;
   localparam logic [pxg_pkg::CSR_INDEX_W-1:0] CSR_SPARE_INDEX = 4'd15;

   typedef struct packed {
      logic [7:0]  gradient;
      logic [10:0] out_row;
      logic [10:0] out_col;
      logic        end_of_frame;
      logic        last_of_run;
   } gradient_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        rsp_tlast;
   logic        rsp_tuser;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [pxg_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [pxg_pkg::CSR_DATA_W-1:0]  csr_data = '0;

   // shared between stimulus, driver and monitor
   logic [7:0]          pending_pixels[$];
   gradient_result_type expected_results[$];
   logic                pixel_taken = 1'b0;
   logic                send_hold = 1'b0;
   logic                steady = 1'b0;
   int                  holds_asked = 0;
   int                  mismatches = 0;

   // predictor state
   logic [11:0]     width_reg = pxg_pkg::IMAGE_WIDTH_RESET;
   logic [11:0]     height_reg = pxg_pkg::IMAGE_HEIGHT_RESET;
   logic [7:0]      older_line [MAX_SIZE];
   logic [7:0]      prev_line [MAX_SIZE];
   logic [1:0][7:0] cur_tap = '0;
   logic [1:0][7:0] prev_tap = '0;
   logic [1:0][7:0] old_tap = '0;
   int unsigned     row_pos = 0;
   int unsigned     col_pos = 0;

   prewitt_x_gradient_filter u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $time, msg);
      mismatches++;
   endtask

   function automatic int unsigned effective_size(input logic [11:0] v);
      if (v == 12'd0) return 1;
      if (32'(v) > MAX_SIZE) return MAX_SIZE;
      return 32'(v);
   endfunction

   // right minus left for an inner output column, left clamps at column 0
   function automatic logic [7:0] inner_diff(input logic [7:0] v,
                                             input logic [1:0][7:0] taps,
                                             input int unsigned c);
      return v - ((c >= 2) ? taps[1] : taps[0]);
   endfunction

   // right minus left for the last column, right repeats the edge pixel
   function automatic logic [7:0] last_diff(input logic [7:0] v,
                                            input logic [1:0][7:0] taps,
                                            input int unsigned c);
      return v - ((c >= 1) ? taps[0] : v);
   endfunction

   function automatic gradient_result_type make_result(input logic [7:0] g,
                                                       input int unsigned row,
                                                       input int unsigned col,
                                                       input logic eof);
      return {g, 11'(row), 11'(col), eof, 1'b0};
   endfunction

   task automatic restart_frame;
      row_pos = 0;
      col_pos = 0;
      cur_tap = '0;
      prev_tap = '0;
      old_tap = '0;
   endtask

   // gradients caused by one accepted pixel, in delivery order
   task automatic predict_gradients(input logic [7:0] pixel);
      int unsigned         w, h, c, r;
      int                  n;
      logic [7:0]          ov, pv, tv, g;
      logic [1:0][7:0]     tt;
      logic                last_col, last_row;
      gradient_result_type found [4];
      w = effective_size(width_reg);
      h = effective_size(height_reg);
      c = (col_pos >= w) ? w - 1 : col_pos;
      r = (row_pos >= h) ? h - 1 : row_pos;
      ov = older_line[c];
      pv = prev_line[c];
      last_col = (c == w - 1);
      last_row = (r == h - 1);
      n = 0;
      // row above the current one, now complete
      if (r >= 1) begin
         tt = (r >= 2) ? old_tap : prev_tap;
         tv = (r >= 2) ? ov : pv;
         if (c >= 1) begin
            g = inner_diff(tv, tt, c) + inner_diff(pv, prev_tap, c)
                + inner_diff(pixel, cur_tap, c);
            found[n] = make_result(g, r - 1, c - 1, 1'b0);
            n++;
         end
         if (last_col) begin
            g = last_diff(tv, tt, c) + last_diff(pv, prev_tap, c)
                + last_diff(pixel, cur_tap, c);
            found[n] = make_result(g, r - 1, w - 1, 1'b0);
            n++;
         end
      end
      // last row uses itself as the row below
      if (last_row) begin
         tt = (r >= 1) ? prev_tap : cur_tap;
         tv = (r >= 1) ? pv : pixel;
         if (c >= 1) begin
            g = inner_diff(tv, tt, c) + inner_diff(pixel, cur_tap, c)
                + inner_diff(pixel, cur_tap, c);
            found[n] = make_result(g, r, c - 1, 1'b0);
            n++;
         end
         if (last_col) begin
            g = last_diff(tv, tt, c) + last_diff(pixel, cur_tap, c)
                + last_diff(pixel, cur_tap, c);
            found[n] = make_result(g, r, w - 1, 1'b1);
            n++;
         end
      end
      for (int i = 0; i < n; i++) begin
         if (i == n - 1) found[i].last_of_run = 1'b1;
         expected_results.push_back(found[i]);
      end
      // shift taps and line stores
      old_tap[1] = old_tap[0];
      old_tap[0] = ov;
      prev_tap[1] = prev_tap[0];
      prev_tap[0] = pv;
      cur_tap[1] = cur_tap[0];
      cur_tap[0] = pixel;
      older_line[c] = pv;
      prev_line[c] = pixel;
      if (last_col) begin
         col_pos = 0;
         row_pos = last_row ? 0 : r + 1;
      end else begin
         col_pos = c + 1;
         row_pos = r;
      end
   endtask

   // pixel driver
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || pixel_taken) begin
         if (pending_pixels.size() != 0 && !send_hold
             && (steady || $urandom_range(99) >= 27)) begin
            req_tvalid <= 1'b1;
            req_tdata  <= pending_pixels.pop_front();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // result receiver, with an occasional long hold-off
   int hold_left = 0;
   int holds_done = 0;
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left = hold_left - 1;
      end else if (holds_done != holds_asked) begin
         rsp_tready <= 1'b0;
         hold_left = HOLD_CYCLES;
         holds_done++;
      end else begin
         rsp_tready <= steady || ($urandom_range(99) >= 27);
      end
   end

   // monitor: register and pixel transfers feed the predictor, results are checked
   always @(posedge clock) begin
      gradient_result_type want;
      pixel_taken = 1'b0;
      if (reset) begin
         width_reg = pxg_pkg::IMAGE_WIDTH_RESET;
         height_reg = pxg_pkg::IMAGE_HEIGHT_RESET;
         restart_frame();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == pxg_pkg::CSR_IMAGE_WIDTH) begin
               width_reg = csr_data;
               restart_frame();
            end else if (csr_index == pxg_pkg::CSR_IMAGE_HEIGHT) begin
               height_reg = csr_data;
               restart_frame();
            end
         end
         if (req_tvalid && req_tready) begin
            pixel_taken = 1'b1;
            predict_gradients(req_tdata);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               report_mismatch($sformatf("unexpected result tdata %h", rsp_tdata));
            end else begin
               want = expected_results.pop_front();
               if (rsp_tdata[7:0] != want.gradient)
                  report_mismatch($sformatf("gradient %0d, expected %0d at row %0d col %0d",
                     rsp_tdata[7:0], want.gradient, want.out_row, want.out_col));
               if (rsp_tdata[18:8] != want.out_row)
                  report_mismatch($sformatf("out_row %0d, expected %0d",
                     rsp_tdata[18:8], want.out_row));
               if (rsp_tdata[29:19] != want.out_col)
                  report_mismatch($sformatf("out_col %0d, expected %0d",
                     rsp_tdata[29:19], want.out_col));
               if (rsp_tdata[31:30] != 2'b00)
                  report_mismatch($sformatf("padding bits %b", rsp_tdata[31:30]));
               if (rsp_tuser != want.end_of_frame)
                  report_mismatch($sformatf("end_of_frame %b, expected %b at row %0d col %0d",
                     rsp_tuser, want.end_of_frame, want.out_row, want.out_col));
               if (rsp_tlast != want.last_of_run)
                  report_mismatch($sformatf("last_of_run %b, expected %b at row %0d col %0d",
                     rsp_tlast, want.last_of_run, want.out_row, want.out_col));
            end
         end
      end
   end

   // watchdog
   initial begin
      int cycle_count;
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("prewitt_x_gradient_filter test failed");
      $finish;
   end

   task automatic queue_pixels(input int count, input bit extremes);
      for (int i = 0; i < count; i++) begin
         if (extremes) pending_pixels.push_back($urandom_range(1) != 0 ? 8'hFF : 8'h00);
         else pending_pixels.push_back(8'($urandom_range(255)));
      end
   endtask

   // wait for every pixel and result to pass, then let the pipeline settle
   task automatic wait_idle;
      @(negedge clock);
      #1;
      while (pending_pixels.size() != 0 || req_tvalid || expected_results.size() != 0)
      begin
         @(negedge clock);
         #1;
      end
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_register(input logic [pxg_pkg::CSR_INDEX_W-1:0] index,
                                 input logic [pxg_pkg::CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_frame_size(input logic [11:0] w, input logic [11:0] h);
      wait_idle();
      write_register(pxg_pkg::CSR_IMAGE_WIDTH, w);
      write_register(pxg_pkg::CSR_IMAGE_HEIGHT, h);
   endtask

   // stimulus
   initial begin
      logic [7:0] corner_pattern [9];
      int random_items;
      int phase;
      int w, h, frames, count, split;
      bit extremes;

      corner_pattern = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255,
                         8'd0, 8'd255, 8'd255};
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset size: first row only, nothing should come out
      queue_pixels(10, 1'b0);

      // small frame with hard edges
      set_frame_size(12'd3, 12'd3);
      foreach (corner_pattern[i]) pending_pixels.push_back(corner_pattern[i]);

      // zero sizes count as one pixel
      set_frame_size(12'd0, 12'd0);
      pending_pixels.push_back(8'hFF);

      // single row
      set_frame_size(12'd4, 12'd1);
      pending_pixels.push_back(8'hFF);
      pending_pixels.push_back(8'h00);
      pending_pixels.push_back(8'hFF);
      pending_pixels.push_back(8'h00);

      // single column, with a write to an unused index mid-frame
      set_frame_size(12'd1, 12'd3);
      pending_pixels.push_back(8'd7);
      wait_idle();
      write_register(CSR_SPARE_INDEX, 12'hFFF);
      pending_pixels.push_back(8'd200);
      pending_pixels.push_back(8'd255);

      // back-pressure: long receiver hold, then a sender pause mid-frame
      set_frame_size(12'd16, 12'd6);
      queue_pixels(96, 1'b0);
      holds_asked++;
      while (pending_pixels.size() > 40) @(negedge clock);
      send_hold = 1'b1;
      while ((req_tvalid && !pixel_taken) || expected_results.size() != 0)
         @(negedge clock);
      send_hold = 1'b0;
      random_items = 96;

      // random frames, some cut short, the first ones with no gaps at all
      phase = 0;
      while (random_items < RANDOM_ITEMS) begin
         w = ($urandom_range(5) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
         h = $urandom_range(6, 1);
         wait_idle();
         steady = (phase <= 1);
         if ($urandom_range(3) == 0) begin
            if ($urandom_range(1) != 0) write_register(pxg_pkg::CSR_IMAGE_WIDTH, 12'(w));
            else write_register(pxg_pkg::CSR_IMAGE_HEIGHT, 12'(h));
            w = effective_size(width_reg);
            h = effective_size(height_reg);
         end else begin
            write_register(pxg_pkg::CSR_IMAGE_WIDTH, 12'(w));
            write_register(pxg_pkg::CSR_IMAGE_HEIGHT, 12'(h));
         end
         frames = $urandom_range(2, 1);
         count = frames * w * h;
         if (w * h > 1 && $urandom_range(5) == 0) count = $urandom_range(w * h - 1, 1);
         if (count > RANDOM_ITEMS - random_items) count = RANDOM_ITEMS - random_items;
         extremes = ($urandom_range(3) == 0);
         if (count > 1 && $urandom_range(9) == 0) begin
            split = $urandom_range(count - 1, 1);
            queue_pixels(split, extremes);
            wait_idle();
            write_register(4'($urandom_range(15, 2)), 12'($urandom_range(4095)));
            queue_pixels(count - split, extremes);
         end else begin
            queue_pixels(count, extremes);
         end
         random_items += count;
         phase++;
      end
      wait_idle();
      steady = 1'b0;

      // wide row, width above the maximum saturates
      set_frame_size(12'hFFF, 12'd1);
      queue_pixels(SATURATE_ITEMS, 1'b0);

      // tall column, height above the maximum saturates
      set_frame_size(12'd1, 12'hFFF);
      queue_pixels(SATURATE_ITEMS, 1'b0);

      wait_idle();
      if (expected_results.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
      if (mismatches == 0) $display("prewitt_x_gradient_filter test passed");
      else $display("prewitt_x_gradient_filter test failed");
      $finish;
   end

endmodule
